// ===== hdl/rgbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbd_pkg
// Widths, mask tables and helpers shared by the RGB to IRGB ordered dither.
// ----------------------------------------------------------------------------
package rgbd_pkg;

	localparam int CH_W  = 8;   // colour channel width
	localparam int PH_W  = 2;   // screen phase width
	localparam int IDX_W = 4;   // palette index width
	localparam int LVL_W = 4;   // dither level width
	localparam int REM_W = 9;   // divisor and remainder width (L + 8 <= 263)
	localparam int SUM_W = 10;  // width of the grey spread sum
	localparam int POS_W = 5;   // bit position inside a 32-bit mask
	localparam int NCH   = 3;   // red, green, blue lanes

	localparam int CH_R = 2;
	localparam int CH_G = 1;
	localparam int CH_B = 0;

	localparam logic [REM_W-1:0] DIV_OFFSET  = REM_W'(8);
	localparam logic [SUM_W-1:0] GREY_SPREAD = SUM_W'(8);

	localparam logic [IDX_W-1:0] NEAR_BLACK      = 4'h0;
	localparam logic [IDX_W-1:0] NEAR_LIGHT_GREY = 4'h7;
	localparam logic [IDX_W-1:0] NEAR_DARK_GREY  = 4'h8;

	typedef logic [31:0] mask_t;

	localparam mask_t DIM_MASKS [16] = '{
		32'h00000000, 32'h88000000, 32'h88002200, 32'h8800AA00,
		32'hAA00AA00, 32'hAA44AA00, 32'hAA44AA11, 32'hAA44AA55,
		32'hAA55AA55, 32'hAADDAA55, 32'hAADDAA77, 32'hAADDAAFF,
		32'hAAFFAAFF, 32'hEEFFAAFF, 32'hEEFFBBFF, 32'hEEFFFFFF
	};

	localparam mask_t BRIGHT_MASKS [16] = '{
		32'h00000000, 32'h88000000, 32'h88002200, 32'h8800AA00,
		32'hAA00AA00, 32'hAA44AA00, 32'hAA44AA11, 32'hAA44AA55,
		32'hAA55AA55, 32'hAADDAA55, 32'hAADDAA77, 32'hAADDAAFF,
		32'hAAFFAAFF, 32'hEEFFAAFF, 32'hEEFFBBFF, 32'hFFFFFFFF
	};

	// Row byte y holds column x at bit 8y + x.
	function automatic logic [POS_W-1:0] mask_pos(input logic [PH_W-1:0] xp,
			input logic [PH_W-1:0] yp);
		return {yp, 1'b0, xp};
	endfunction

	function automatic logic dim_bit(input logic [LVL_W-1:0] lvl,
			input logic [POS_W-1:0] pos);
		mask_t m;
		m = DIM_MASKS[lvl];
		return m[pos];
	endfunction

	function automatic logic bright_bit(input logic [LVL_W-1:0] lvl,
			input logic [POS_W-1:0] pos);
		mask_t m;
		m = BRIGHT_MASKS[lvl];
		return m[pos];
	endfunction

endpackage

// ===== hdl/rgbd_pix_if.sv =====
// ----------------------------------------------------------------------------
// rgbd_pix_if
// Pixel channel: screen phase and 24-bit colour with valid/ready.
// ----------------------------------------------------------------------------
interface rgbd_pix_if;
	import rgbd_pkg::*;

	logic             valid;
	logic             ready;
	logic [PH_W-1:0]  x_phase;
	logic [PH_W-1:0]  y_phase;
	logic [CH_W-1:0]  red_in;
	logic [CH_W-1:0]  green_in;
	logic [CH_W-1:0]  blue_in;

	modport source (output valid, x_phase, y_phase, red_in, green_in, blue_in,
		input ready);
	modport sink (input valid, x_phase, y_phase, red_in, green_in, blue_in,
		output ready);
endinterface

// ===== hdl/rgbd_idx_if.sv =====
// ----------------------------------------------------------------------------
// rgbd_idx_if
// Result channel: dithered palette index and nearest solid colour.
// ----------------------------------------------------------------------------
interface rgbd_idx_if;
	import rgbd_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] pixel_index;
	logic [IDX_W-1:0] nearest_color;

	modport source (output valid, pixel_index, nearest_color, input ready);
	modport sink (input valid, pixel_index, nearest_color, output ready);
endinterface

// ===== hdl/rgbd_div2.sv =====
// ----------------------------------------------------------------------------
// rgbd_div2
// Two restoring division steps: yields two quotient bits and the new remainder.
// ----------------------------------------------------------------------------
module rgbd_div2 (
	input  logic [rgbd_pkg::REM_W-1:0] rem_in,
	input  logic [rgbd_pkg::REM_W-1:0] divisor,
	output logic [rgbd_pkg::REM_W-1:0] rem_out,
	output logic [1:0]                 quo
);
	import rgbd_pkg::*;

	logic [REM_W:0]   sh1;
	logic [REM_W:0]   sh2;
	logic [REM_W-1:0] r1;

	// The remainder stays below the divisor, so a doubled value fits one extra bit.
	always_comb begin
		sh1 = {rem_in, 1'b0};
		if (sh1 >= {1'b0, divisor}) begin
			quo[1] = 1'b1;
			r1     = REM_W'(sh1 - {1'b0, divisor});
		end else begin
			quo[1] = 1'b0;
			r1     = sh1[REM_W-1:0];
		end
		sh2 = {r1, 1'b0};
		if (sh2 >= {1'b0, divisor}) begin
			quo[0]  = 1'b1;
			rem_out = REM_W'(sh2 - {1'b0, divisor});
		end else begin
			quo[0]  = 1'b0;
			rem_out = sh2[REM_W-1:0];
		end
	end
endmodule

// ===== hdl/rgb_to_irgb_ordered_dither_top.sv =====
// ----------------------------------------------------------------------------
// rgb_to_irgb_ordered_dither_top
// Reduces 24-bit RGB pixels to a 4-bit IRGB index with a 4x4 ordered dither.
// ----------------------------------------------------------------------------
// Usage: the pixel channel (pix) carries the pixel's column and row modulo 4
// and its red, green and blue values; the result channel (res) returns the
// dithered IRGB index and the nearest solid colour. Both are valid/ready
// channels and a transaction completes when valid and ready are high together.
// Every pixel gives exactly one result, in order; pixels are independent.
// A pixel taken on pix passes through the stage 1 to 4 registers before it is
// offered on res; throughput is one pixel per cycle while res is ready. The
// four stages are: channel maximum, two division steps of c*16/(L+8) for the
// three channels, two more division steps, then mask lookup and selection.
// Each stage has its own valid bit and takes new data whenever it is empty or
// the next stage moves, so bubbles close up and a stalled receiver only halts
// the stages that are full. With all four stages full and res.ready low,
// pix.ready falls and nothing is lost or repeated.
// Reset clears all valid bits, so pix.ready is high when reset is released.
// ----------------------------------------------------------------------------
module rgb_to_irgb_ordered_dither_top (
	input  logic       clk,
	input  logic       arst_n,
	rgbd_pix_if.sink   pix,
	rgbd_idx_if.source res
);
	import rgbd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// Stage 1 registers
	logic [PH_W-1:0]           xp_s1, yp_s1;
	logic [NCH-1:0][CH_W-1:0]  ch_s1;
	logic [CH_W-1:0]           l_s1;
	// Stage 2 registers
	logic [PH_W-1:0]           xp_s2, yp_s2;
	logic [NCH-1:0][CH_W-1:0]  ch_s2;
	logic [CH_W-1:0]           l_s2;
	logic [REM_W-1:0]          d_s2;
	logic                      grey_s2;
	logic [NCH-1:0][REM_W-1:0] rem_s2;
	logic [NCH-1:0][1:0]       qhi_s2;
	// Stage 3 registers
	logic [PH_W-1:0]           xp_s3, yp_s3;
	logic [NCH-1:0][CH_W-1:0]  ch_s3;
	logic [CH_W-1:0]           l_s3;
	logic                      grey_s3;
	logic [NCH-1:0][LVL_W-1:0] q_s3;
	// Stage 4 (output) registers
	logic [IDX_W-1:0]          pix_s4, near_s4;

	logic [CH_W-1:0]           l_max;
	logic [REM_W-1:0]          d_c;
	logic [SUM_W-1:0]          spread_c;
	logic [NCH-1:0][REM_W-1:0] rem2_c, rem3_c;
	logic [NCH-1:0][1:0]       qhi_c, qlo_c;
	logic [POS_W-1:0]          pos_c;
	logic [IDX_W-1:0]          pix_c, near_c;
	logic                      m_c;

	// Handshake: a stage loads when it is empty or its contents move on.
	assign rdy4      = !v_s4 || res.ready;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign pix.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: largest channel.
	always_comb begin
		l_max = pix.red_in;
		if (pix.green_in > l_max) l_max = pix.green_in;
		if (pix.blue_in > l_max) l_max = pix.blue_in;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && pix.valid) begin
			xp_s1       <= pix.x_phase;
			yp_s1       <= pix.y_phase;
			ch_s1[CH_R] <= pix.red_in;
			ch_s1[CH_G] <= pix.green_in;
			ch_s1[CH_B] <= pix.blue_in;
			l_s1        <= l_max;
		end
	end

	// Stage 2: divisor, grey spread and the upper two quotient bits.
	assign d_c      = REM_W'(l_s1) + DIV_OFFSET;
	assign spread_c = SUM_W'(l_s1 - ch_s1[CH_R]) + SUM_W'(l_s1 - ch_s1[CH_G])
		+ SUM_W'(l_s1 - ch_s1[CH_B]);

	// Each channel is at most L, so it starts below the divisor L + 8.
	for (genvar k = 0; k < NCH; k++) begin : g_div
		rgbd_div2 u_div_hi (
			.rem_in  (REM_W'(ch_s1[k])),
			.divisor (d_c),
			.rem_out (rem2_c[k]),
			.quo     (qhi_c[k])
		);
		rgbd_div2 u_div_lo (
			.rem_in  (rem_s2[k]),
			.divisor (d_s2),
			.rem_out (rem3_c[k]),
			.quo     (qlo_c[k])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			xp_s2   <= xp_s1;
			yp_s2   <= yp_s1;
			ch_s2   <= ch_s1;
			l_s2    <= l_s1;
			d_s2    <= d_c;
			grey_s2 <= spread_c < GREY_SPREAD;
			rem_s2  <= rem2_c;
			qhi_s2  <= qhi_c;
		end
	end

	// Stage 3: lower two quotient bits.
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			xp_s3   <= xp_s2;
			yp_s3   <= yp_s2;
			ch_s3   <= ch_s2;
			l_s3    <= l_s2;
			grey_s3 <= grey_s2;
			for (int k = 0; k < NCH; k++) begin
				q_s3[k] <= {qhi_s2[k], qlo_c[k]};
			end
		end
	end

	// Stage 4: mode selection and mask lookup.
	always_comb begin
		pos_c  = mask_pos(xp_s3, yp_s3);
		m_c    = dim_bit(l_s3[5:2], pos_c);
		pix_c  = '0;
		near_c = NEAR_BLACK;
		if (l_s3[7]) begin
			pix_c  = {bright_bit(l_s3[6:3], pos_c), bright_bit(q_s3[CH_R], pos_c),
				bright_bit(q_s3[CH_G], pos_c), bright_bit(q_s3[CH_B], pos_c)};
			near_c = {1'b1, ch_s3[CH_R][7], ch_s3[CH_G][7], ch_s3[CH_B][7]};
		end else if (grey_s3) begin
			if (l_s3[6]) begin
				// Light grey mix: intensity is the complement of the colour mask.
				pix_c  = {!m_c, m_c, m_c, m_c};
				near_c = NEAR_LIGHT_GREY;
			end else begin
				pix_c  = {m_c, 3'b000};
				near_c = l_s3[5] ? NEAR_DARK_GREY : NEAR_BLACK;
			end
		end else begin
			pix_c  = {1'b0, dim_bit(ch_s3[CH_R][6:3], pos_c),
				dim_bit(ch_s3[CH_G][6:3], pos_c), dim_bit(ch_s3[CH_B][6:3], pos_c)};
			near_c = {1'b0, ch_s3[CH_R][6], ch_s3[CH_G][6], ch_s3[CH_B][6]};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			pix_s4  <= pix_c;
			near_s4 <= near_c;
		end
	end

	assign res.valid         = v_s4;
	assign res.pixel_index   = pix_s4;
	assign res.nearest_color = near_s4;

	// A transaction taken on the pixel channel occupies stage 1 next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready |=> v_s1)
		else $error("accepted pixel did not enter stage 1");

	// A full stage behind a stalled output stage keeps its contents.
	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !res.ready && v_s3 |=> v_s3 && $stable(q_s3) && $stable(l_s3))
		else $error("stage 3 changed while the output was stalled");

	// Division remainders always stay below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> rem_s2[CH_R] < d_s2 && rem_s2[CH_G] < d_s2 && rem_s2[CH_B] < d_s2)
		else $error("division remainder out of range");

	// The final remainders stay below the divisor as well.
	a_rem_final_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> rem3_c[CH_R] < d_s2 && rem3_c[CH_G] < d_s2 && rem3_c[CH_B] < d_s2)
		else $error("final division remainder out of range");

	// A bright pixel always yields a nearest colour with the intensity bit set.
	a_bright_near: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rdy4 && l_s3[7] |=> res.valid && res.nearest_color[3])
		else $error("bright pixel lost its intensity bit");
endmodule

// ===== verif/rgb_to_irgb_ordered_dither_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_irgb_ordered_dither_checker
// Watches both channels of the ordered dither. Every pixel transaction is
// turned into an expected IRGB index and nearest colour, which are compared
// with the results in arrival order. Counts mismatches and results still owed.
// ----------------------------------------------------------------------------
module rgb_to_irgb_ordered_dither_checker (
	input  logic clk,
	input  logic arst_n,
	rgbd_pix_if  pix,
	rgbd_idx_if  res,
	output int   err_count,
	output int   pending
);
	import rgbd_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0] pixel_index;
		logic [IDX_W-1:0] nearest_color;
	} irgb_t;

	// Ordered dither levels. The bright set differs only at the top level,
	// where every bit is set.
	localparam logic [31:0] LEVEL_MASKS [16] = '{
		32'h00000000, 32'h88000000, 32'h88002200, 32'h8800AA00,
		32'hAA00AA00, 32'hAA44AA00, 32'hAA44AA11, 32'hAA44AA55,
		32'hAA55AA55, 32'hAADDAA55, 32'hAADDAA77, 32'hAADDAAFF,
		32'hAAFFAAFF, 32'hEEFFAAFF, 32'hEEFFBBFF, 32'hEEFFFFFF
	};

	irgb_t owed_irgb [$];

	function automatic logic [31:0] level_mask(input int unsigned level, input bit bright);
		if (bright && level == 15)
			return 32'hFFFFFFFF;
		return LEVEL_MASKS[level];
	endfunction

	function automatic irgb_t dither_pixel(input logic [PH_W-1:0] xp, input logic [PH_W-1:0] yp,
			input logic [CH_W-1:0] r, input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		int unsigned lum, divisor, spread, pos;
		logic [31:0] mi, mr, mg, mb, grey;
		irgb_t out;
		lum = r;
		if (g > lum) lum = g;
		if (b > lum) lum = b;
		if (lum > 127) begin
			divisor = lum + 8;
			mi = level_mask((lum >> 3) & 15, 1'b1);
			mr = level_mask(((int'(r) * 16) / divisor) & 15, 1'b1);
			mg = level_mask(((int'(g) * 16) / divisor) & 15, 1'b1);
			mb = level_mask(((int'(b) * 16) / divisor) & 15, 1'b1);
			out.nearest_color = {1'b1, r[7], g[7], b[7]};
		end else begin
			spread = 3 * lum - int'(r) - int'(g) - int'(b);
			if (spread < 8 && lum > 63) begin
				// Light grey: the intensity plane fills the holes of the RGB mask.
				grey = level_mask(((lum - 64) >> 2) & 15, 1'b0);
				mi = ~grey;
				mr = grey;
				mg = grey;
				mb = grey;
				out.nearest_color = NEAR_LIGHT_GREY;
			end else if (spread < 8) begin
				mi = level_mask((lum >> 2) & 15, 1'b0);
				mr = '0;
				mg = '0;
				mb = '0;
				out.nearest_color = (lum > 31) ? NEAR_DARK_GREY : NEAR_BLACK;
			end else begin
				mi = '0;
				mr = level_mask((r >> 3) & 15, 1'b0);
				mg = level_mask((g >> 3) & 15, 1'b0);
				mb = level_mask((b >> 3) & 15, 1'b0);
				out.nearest_color = {1'b0, r[6], g[6], b[6]};
			end
		end
		pos = int'(yp) * 8 + int'(xp);
		out.pixel_index = {mi[pos], mr[pos], mg[pos], mb[pos]};
		return out;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		irgb_t want;
		if (!arst_n) begin
			err_count <= 0;
			pending <= 0;
		end else begin
			if (pix.valid && pix.ready)
				owed_irgb.push_back(dither_pixel(pix.x_phase, pix.y_phase, pix.red_in,
					pix.green_in, pix.blue_in));
			if (res.valid && res.ready) begin
				if (owed_irgb.size() == 0) begin
					$error("result transaction with no pixel owed: index %0h, nearest %0h",
						res.pixel_index, res.nearest_color);
					err_count <= err_count + 1;
				end else begin
					want = owed_irgb.pop_front();
					if (res.pixel_index !== want.pixel_index ||
							res.nearest_color !== want.nearest_color)
						err_count <= err_count + 1;
					if (res.pixel_index !== want.pixel_index)
						$error("pixel_index: expected %0h, actual %0h",
							want.pixel_index, res.pixel_index);
					if (res.nearest_color !== want.nearest_color)
						$error("nearest_color: expected %0h, actual %0h",
							want.nearest_color, res.nearest_color);
				end
			end
			pending <= owed_irgb.size();
		end
	end

endmodule

// ===== verif/rgb_to_irgb_ordered_dither_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_irgb_ordered_dither_top_tb
// Drives pixels into the ordered dither with random gaps and receiver stalls,
// including one long stall that fills the pipeline. A directed set covers the
// region boundaries; random pixels follow, biased to bright, near-grey and dim.
// The checker beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module rgb_to_irgb_ordered_dither_top_tb;
	import rgbd_pkg::*;

	localparam int N_RANDOM   = 400;
	localparam int HOLD_AT    = 150;   // random pixel at which the long stall starts
	localparam int QUIET_FROM = 340;   // no idling from this random pixel on
	localparam int HOLD_LEN   = 300;
	localparam int STUCK_LIMIT = 3000;

	typedef struct packed {
		logic [PH_W-1:0] x_phase;
		logic [PH_W-1:0] y_phase;
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} pixel_t;

	// Region boundaries: black, white, pure colours, bright edge, grey edges,
	// grey spread of seven and of eight, top dim level, top bright level.
	localparam logic [23:0] DIRECTED_RGB [24] = '{
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
		24'h0000FF, 24'h808080, 24'h7F7F7F, 24'h404040,
		24'h3F3F3F, 24'h202020, 24'h1F1F1F, 24'h646160,
		24'h646060, 24'h7F0000, 24'h007F00, 24'h00007F,
		24'h404000, 24'h7C7C7C, 24'hF8F8F8, 24'hFF7F01,
		24'h807F7E, 24'h3F3D3C, 24'hC04080, 24'h074000
	};

	logic clk;
	logic arst_n;
	int   err_count;
	int   pending;
	bit   quiet;
	bit   hold_req;
	int   stuck_cycles;

	rgbd_pix_if pix_ch ();
	rgbd_idx_if res_ch ();

	rgb_to_irgb_ordered_dither_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.res    (res_ch)
	);

	rgb_to_irgb_ordered_dither_checker dither_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_ch),
		.res       (res_ch),
		.err_count (err_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic pixel_t random_pixel();
		pixel_t px;
		int kind, lum, d1, d2, pick;
		logic [CH_W-1:0] c [3];
		px = pixel_t'($urandom);
		kind = $urandom_range(0, 9);
		lum = 0;
		if (kind <= 2)
			return px;
		if (kind <= 4) begin
			lum = $urandom_range(128, 255);
			c[0] = CH_W'(lum);
			c[1] = CH_W'($urandom_range(0, lum));
			c[2] = CH_W'($urandom_range(0, lum));
		end else if (kind <= 7) begin
			// Near grey: the other two channels trail the largest by a small amount.
			lum = $urandom_range(0, 127);
			d1 = $urandom_range(0, 7);
			d2 = $urandom_range(0, 8 - d1);
			if (d1 > lum) d1 = lum;
			if (d2 > lum) d2 = lum;
			c[0] = CH_W'(lum);
			c[1] = CH_W'(lum - d1);
			c[2] = CH_W'(lum - d2);
		end else begin
			c[0] = CH_W'($urandom_range(0, 127));
			c[1] = CH_W'($urandom_range(0, 127));
			c[2] = CH_W'($urandom_range(0, 127));
		end
		pick = $urandom_range(0, 2);
		px.red_in = c[pick];
		px.green_in = c[(pick + 1) % 3];
		px.blue_in = c[(pick + 2) % 3];
		return px;
	endfunction

	task automatic offer_pixel(input pixel_t px);
		pix_ch.valid <= 1'b1;
		pix_ch.x_phase <= px.x_phase;
		pix_ch.y_phase <= px.y_phase;
		pix_ch.red_in <= px.red_in;
		pix_ch.green_in <= px.green_in;
		pix_ch.blue_in <= px.blue_in;
		@(posedge clk);
		while (pix_ch.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_input(input int cycles);
		pix_ch.valid <= 1'b0;
		{pix_ch.x_phase, pix_ch.y_phase, pix_ch.red_in, pix_ch.green_in,
			pix_ch.blue_in} <= pixel_t'($urandom);
		repeat (cycles) @(negedge clk);
	endtask

	task automatic maybe_pause();
		if (!quiet && $urandom_range(0, 5) == 0)
			pause_input($urandom_range(1, 15));
	endtask

	// Receiver: random stall bursts, one long hold-off on request, none at the end.
	initial begin
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done = 1'b0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (hold_req && !hold_done) begin
				res_ch.ready <= 1'b0;
				stall_left = HOLD_LEN - 1;
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 14);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which neither channel completes a transaction.
	always @(posedge clk) begin
		if (!arst_n) begin
			stuck_cycles <= 0;
		end else begin
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("[rgb_to_irgb_ordered_dither_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		pixel_t px;
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.x_phase = '0;
		pix_ch.y_phase = '0;
		pix_ch.red_in = '0;
		pix_ch.green_in = '0;
		pix_ch.blue_in = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < 24; i++) begin
			px.x_phase = i[1:0];
			px.y_phase = i[3:2];
			{px.red_in, px.green_in, px.blue_in} = DIRECTED_RGB[i];
			offer_pixel(px);
			maybe_pause();
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == HOLD_AT)
				hold_req = 1'b1;
			if (i == QUIET_FROM)
				quiet = 1'b1;
			offer_pixel(random_pixel());
			maybe_pause();
		end
		pix_ch.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0 && pending == 0)
			$display("[rgb_to_irgb_ordered_dither_top] OK");
		else
			$display("[rgb_to_irgb_ordered_dither_top] ERROR");
		$finish;
	end

endmodule
